>>> rtl/sld_pkg.sv
// ---------------------------------------------------------------------------
// sld_pkg: shared types and constants of the sync/length packet deframer
// Holds the frame parser stage codes, configuration register indexes and
// the result item that travels from the parser to the output skid stage.
// ---------------------------------------------------------------------------
package sld_pkg;

  // Parser stages; codes six and seven behave as hunting.
  localparam logic [2:0] StHunt    = 3'd0;
  localparam logic [2:0] StType    = 3'd1;
  localparam logic [2:0] StFlags   = 3'd2;
  localparam logic [2:0] StLenHigh = 3'd3;
  localparam logic [2:0] StLenLow  = 3'd4;
  localparam logic [2:0] StPayload = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSyncByte  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxLength = 2'd1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  SyncByteReset  = 8'd88;
  localparam logic [15:0] MaxLengthReset = 16'd512;

  // One result item.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic [15:0] payload_index;
    logic        packet_done;
    logic        length_error;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] frame_length;
  } sld_result_t;

endpackage

>>> rtl/sld_skid.sv
// ---------------------------------------------------------------------------
// sld_skid: output register with a skid stage
// Decouples the parser's ready from the downstream ready so that one more
// item can be taken while a finished result waits to be consumed.
// ---------------------------------------------------------------------------
module sld_skid
  import sld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sld_result_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sld_result_t out_data_o
);

  logic        out_valid_q;
  logic        skid_valid_q;
  sld_result_t out_q;
  sld_result_t skid_q;
  logic        in_fire;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= in_data_i;
      end
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/sync_length_packet_deframer.sv
// ---------------------------------------------------------------------------
// sync_length_packet_deframer: sync byte / length prefixed frame receiver
// Parses a byte stream into frames and streams out the payload bytes.
// ---------------------------------------------------------------------------
// Usage:
// Each input item on the s_axis channel is one received link byte. The
// block hunts for the configured sync byte, then takes a type byte, a
// flags byte and a big-endian 16-bit payload length, and then passes the
// payload bytes through. Every input item yields exactly one result item
// on the m_axis channel. tuser flags a payload byte, tlast marks the item
// that completes a packet (the last payload byte, or the low length byte
// of an empty packet), and tdata carries the byte, its index and the
// current frame header. A length above the configured maximum length flags
// a length error and sends the parser back to hunting.
// Throughput is one item per cycle while the receiver keeps up; the result
// comes from the single parser stage and is held in the output register.
// A two-entry output register plus skid stage lets the block take one more
// byte after the receiver stalls; s_axis_tready then drops until the
// receiver drains it. Reset clears the parser to hunting, empties the
// output stage and restores the register defaults (sync byte 88, maximum
// length 512). Configuration writes take effect on the next byte and must be
// made only while the block is idle; the user, not the block, ensures this.
// ---------------------------------------------------------------------------
module sync_length_packet_deframer
  import sld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] payload_data, [23:8] payload_index, [24] length_error,
  // [32:25] frame_type, [40:33] frame_flags, [56:41] frame_length,
  // [63:57] zero
  output logic [63:0]         m_axis_tdata,
  output logic                m_axis_tuser,   // [0] payload_valid
  output logic                m_axis_tlast    // packet_done
);

  logic [7:0]  sync_byte_q;
  logic [15:0] max_len_q;

  logic [2:0]  stage_q, stage_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] byte_pos_q, byte_pos_d;

  sld_result_t res;
  sld_result_t out_res;
  logic        in_fire;
  logic [15:0] full_len;
  logic [15:0] left_after;

  assign in_fire = s_axis_tvalid & s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q <= SyncByteReset;
      max_len_q   <= MaxLengthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSyncByte:  sync_byte_q <= cfg_data_i[7:0];
        CfgMaxLength: max_len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser step for one byte.
  always_comb begin
    stage_d      = stage_q;
    bytes_left_d = bytes_left_q;
    length_d     = length_q;
    type_d       = type_q;
    flags_d      = flags_q;
    byte_pos_d   = byte_pos_q;
    full_len     = {length_q[15:8], s_axis_tdata};
    left_after   = bytes_left_q;

    res               = '0;

    case (stage_q)
      StType: begin
        type_d  = s_axis_tdata;
        stage_d = StFlags;
      end
      StFlags: begin
        flags_d = s_axis_tdata;
        stage_d = StLenHigh;
      end
      StLenHigh: begin
        length_d = {s_axis_tdata, 8'd0};
        stage_d  = StLenLow;
      end
      StLenLow: begin
        length_d   = full_len;
        byte_pos_d = '0;
        if (full_len == 16'd0) begin
          res.packet_done = 1'b1;
          stage_d         = StHunt;
        end else if (full_len > max_len_q) begin
          // Oversized frame: report it, then drop back to hunting.
          res.length_error = 1'b1;
          stage_d          = StHunt;
          bytes_left_d     = '0;
          length_d         = '0;
        end else begin
          bytes_left_d = full_len;
          stage_d      = StPayload;
        end
      end
      StPayload: begin
        if (bytes_left_q != 16'd0) begin
          res.payload_valid = 1'b1;
          res.payload_data  = s_axis_tdata;
          res.payload_index = byte_pos_q;
          byte_pos_d        = byte_pos_q + 16'd1;
          left_after        = bytes_left_q - 16'd1;
          bytes_left_d      = left_after;
        end
        if (left_after == 16'd0) begin
          res.packet_done = 1'b1;
          stage_d         = StHunt;
        end
      end
      default: begin
        stage_d = (s_axis_tdata == sync_byte_q) ? StType : StHunt;
      end
    endcase

    res.frame_type   = type_d;
    res.frame_flags  = flags_d;
    // On a length error the rejected length is still shown.
    res.frame_length = res.length_error ? full_len : length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q      <= StHunt;
      bytes_left_q <= '0;
      length_q     <= '0;
      type_q       <= '0;
      flags_q      <= '0;
      byte_pos_q   <= '0;
    end else if (in_fire) begin
      stage_q      <= stage_d;
      bytes_left_q <= bytes_left_d;
      length_q     <= length_d;
      type_q       <= type_d;
      flags_q      <= flags_d;
      byte_pos_q   <= byte_pos_d;
    end
  end

  sld_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.frame_length, out_res.frame_flags,
                         out_res.frame_type, out_res.length_error,
                         out_res.payload_index, out_res.payload_data};
  assign m_axis_tuser = out_res.payload_valid;
  assign m_axis_tlast = out_res.packet_done;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the sync/length packet deframer
// Feeds link bytes into the input stream and predicts every result item with
// a cycle-free model of the frame parser. It compares each result item with
// the oldest prediction while both stream sides stall at random in most phases.
// ---------------------------------------------------------------------------
module tb_top;
  import sld_pkg::*;

  // The run is stopped here if the block stops making progress.
  localparam int unsigned CycleLimit = 400000;
  // This register index is not decoded by the block, so writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;     // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] payload_data, [23:8] payload_index, [24] length_error,
  // [32:25] frame_type, [40:33] frame_flags, [56:41] frame_length, [63:57] zero
  logic [63:0]         m_axis_tdata;
  logic                m_axis_tuser;          // [0] payload_valid
  logic                m_axis_tlast;          // packet_done

  sync_length_packet_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Parser state and register copy of the prediction.
  typedef struct packed {
    logic [2:0]  stage;
    logic [15:0] bytes_left;
    logic [15:0] length;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [15:0] pos;
  } parser_state_t;

  typedef struct packed {
    logic [7:0]  sync;
    logic [15:0] max_len;
  } deframer_cfg_t;

  // Two copies of the parser are kept. The checking copy follows the bytes
  // the block really takes. The generator copy follows the bytes as they are
  // queued, so the generator always knows where the parser will stand.
  parser_state_t rx_parser, gen_parser;
  deframer_cfg_t rx_cfg, gen_cfg;

  logic [7:0]  link_bytes[$];
  sld_result_t expected_results[$];

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 88;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned stray_results = 0;
  int unsigned payload_seen = 0;
  int unsigned packets_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned cycle_count = 0;

  // The first bytes exercise the hunt, an empty packet, two oversized lengths
  // and a short packet whose payload carries the sync value and both byte extremes.
  // These bytes assume the reset registers: sync 8'h58, maximum length 512.
  logic [7:0] intro_bytes [25] = '{
    8'h00, 8'hFF,
    8'h58, 8'hFF, 8'h00, 8'h00, 8'h00,
    8'h58, 8'h12, 8'h34, 8'h02, 8'h01,
    8'h58, 8'hA5, 8'h5A, 8'h00, 8'h03, 8'h58, 8'hFF, 8'h00,
    8'h58, 8'h01, 8'h02, 8'hFF, 8'hFF
  };

  function automatic void apply_cfg(inout deframer_cfg_t c, input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      CfgSyncByte:  c.sync = val[7:0];
      CfgMaxLength: c.max_len = val;
      default: ;
    endcase
  endfunction

  // Consumes one link byte and returns the result item it causes.
  function automatic sld_result_t deframe_byte(inout parser_state_t st,
                                               input deframer_cfg_t c, input logic [7:0] b);
    sld_result_t r;
    logic        dropped;
    logic [15:0] dropped_len;
    r = '0;
    dropped = 1'b0;
    dropped_len = '0;
    case (st.stage)
      StType: begin
        st.ftype = b;
        st.stage = StFlags;
      end
      StFlags: begin
        st.flags = b;
        st.stage = StLenHigh;
      end
      StLenHigh: begin
        // Until the low byte arrives, the length shows only the high byte.
        st.length = {b, 8'h00};
        st.stage = StLenLow;
      end
      StLenLow: begin
        st.length = st.length | {8'h00, b};
        st.pos = '0;
        if (st.length == 16'd0) begin
          // An empty packet completes on its low length byte.
          r.packet_done = 1'b1;
          st.stage = StHunt;
        end else if (st.length > c.max_len) begin
          // The oversized length is still shown once, then the frame is dropped.
          r.length_error = 1'b1;
          dropped = 1'b1;
          dropped_len = st.length;
          st.stage = StHunt;
          st.bytes_left = '0;
          st.length = '0;
        end else begin
          st.bytes_left = st.length;
          st.stage = StPayload;
        end
      end
      StPayload: begin
        if (st.bytes_left != 16'd0) begin
          r.payload_valid = 1'b1;
          r.payload_data = b;
          r.payload_index = st.pos;
          st.pos = st.pos + 16'd1;
          st.bytes_left = st.bytes_left - 16'd1;
        end
        if (st.bytes_left == 16'd0) begin
          r.packet_done = 1'b1;
          st.stage = StHunt;
        end
      end
      default: begin
        // Hunting, and the unused stage codes behave the same way.
        st.stage = (b == c.sync) ? StType : StHunt;
      end
    endcase
    r.frame_type = st.ftype;
    r.frame_flags = st.flags;
    r.frame_length = dropped ? dropped_len : st.length;
    return r;
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    void'(deframe_byte(gen_parser, gen_cfg, b));
    link_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // Random line noise, with the sync value mixed in so that headers start and
  // break off. A length that would be accepted is kept short, so that noise
  // never locks the parser into a long payload.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = ($urandom_range(4) == 0) ? gen_cfg.sync : 8'($urandom_range(255));
    if (gen_parser.stage == StLenHigh && b != 8'h00 && {b, 8'h00} <= gen_cfg.max_len) begin
      b = 8'h00;
    end
    if (gen_parser.stage == StLenLow && gen_parser.length == 16'd0 && b > 8'd16 &&
        {8'h00, b} <= gen_cfg.max_len) begin
      b = b & 8'h0F;
    end
    return b;
  endfunction

  // Picks a header length: empty, exactly the maximum, one above it, far
  // above it, or a short ordinary packet.
  function automatic logic [15:0] pick_length();
    int unsigned max_len;
    int unsigned len;
    max_len = gen_cfg.max_len;
    len = $urandom_range(1, 12);
    case ($urandom_range(9))
      0: len = 0;
      1: if (max_len <= 40) len = max_len;
      2: if (max_len < 65535) len = max_len + 1;
      3: if (max_len < 65535) len = $urandom_range(65535, max_len + 1);
      default: ;
    endcase
    return 16'(len);
  endfunction

  // A well-formed frame with random header and payload contents.
  function automatic void queue_frame(input logic [15:0] len);
    queue_byte(gen_cfg.sync);
    queue_byte(8'($urandom_range(255)));
    queue_byte(8'($urandom_range(255)));
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
    if (len != 16'd0 && len <= gen_cfg.max_len) begin
      for (int unsigned i = 0; i < len; i++) begin
        queue_byte(($urandom_range(7) == 0) ? gen_cfg.sync : 8'($urandom_range(255)));
      end
    end
  endfunction

  // Mostly well-formed frames; the rest is noise and torn headers, each
  // followed by enough bytes to bring the parser back to hunting.
  function automatic void queue_traffic(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      if ($urandom_range(99) < 75) begin
        queue_frame(pick_length());
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(noise_byte());
        while (gen_parser.stage != StHunt) queue_byte(noise_byte());
      end
    end
  endfunction

  // Waits until every queued byte has been taken and every result has come
  // back. A stale sample here can only make the wait longer.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    apply_cfg(gen_cfg, idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One traffic phase under new registers. Halfway through, the sender holds
  // off until the block has returned every result.
  task automatic run_phase(input logic [7:0] sync, input logic [15:0] max_len,
                           input int unsigned send_pct, input int unsigned recv_pct);
    write_reg(CfgSyncByte, {8'h00, sync});
    write_reg(CfgMaxLength, max_len);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_traffic(65);
    wait_drained();
    queue_traffic(65);
    wait_drained();
  endtask

  // Sender. A new byte is offered only once the previous one has been taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= link_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver and checker. Each byte the block takes is predicted at that
  // edge. A register write takes effect only from the next byte, so it is
  // applied after the prediction. Each result item taken is compared with
  // the oldest prediction.
  always @(posedge clk_i) begin
    sld_result_t want;
    sld_result_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(deframe_byte(rx_parser, rx_cfg, s_axis_tdata));
        bytes_taken++;
      end
      if (cfg_we_i) apply_cfg(rx_cfg, cfg_idx_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_valid = m_axis_tuser;
        got.payload_data = m_axis_tdata[7:0];
        got.payload_index = m_axis_tdata[23:8];
        got.packet_done = m_axis_tlast;
        got.length_error = m_axis_tdata[24];
        got.frame_type = m_axis_tdata[32:25];
        got.frame_flags = m_axis_tdata[40:33];
        got.frame_length = m_axis_tdata[56:41];
        if (expected_results.size() == 0) begin
          stray_results++;
          $display("unexpected result item with no byte waiting for it: tdata=%h", m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          payload_seen += want.payload_valid;
          packets_seen += want.packet_done;
          errors_seen += want.length_error;
          if (got !== want || m_axis_tdata[63:57] !== 7'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d differs: expected valid=%0b data=%h index=%0d done=%0b",
                       results_checked, want.payload_valid, want.payload_data,
                       want.payload_index, want.packet_done);
              $display("  err=%0b type=%h flags=%h length=%0d; got valid=%0b data=%h",
                       want.length_error, want.frame_type, want.frame_flags,
                       want.frame_length, got.payload_valid, got.payload_data);
              $display("  index=%0d done=%0b err=%0b type=%h flags=%h length=%0d pad=%h",
                       got.payload_index, got.packet_done, got.length_error, got.frame_type,
                       got.frame_flags, got.frame_length, m_axis_tdata[63:57]);
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned failures;
    rx_parser = '0;
    gen_parser = '0;
    rx_cfg = '{sync: SyncByteReset, max_len: MaxLengthReset};
    gen_cfg = rx_cfg;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed bytes under the reset registers.
    foreach (intro_bytes[i]) queue_byte(intro_bytes[i]);
    wait_drained();

    // The spare index must leave both registers alone.
    write_reg(CfgIdxSpare, 16'hFFFF);
    queue_frame(16'd3);
    queue_frame(16'd0);
    wait_drained();

    // Register extremes first, then small random maxima that are hit
    // exactly and exceeded by one.
    run_phase(8'h00, 16'h0000, 36, 88);
    run_phase(8'hFF, 16'hFFFF, 88, 36);
    run_phase(8'($urandom_range(255)), 16'($urandom_range(1, 8)), 0, 0);
    run_phase(8'($urandom_range(255)), 16'($urandom_range(9, 40)), 0, 0);

    failures = mismatches + stray_results + expected_results.size();
    $display("Checked %0d result items from %0d link bytes: %0d payload bytes, %0d packets done,",
             results_checked, bytes_taken, payload_seen, packets_seen);
    $display("%0d oversized lengths dropped, over five register settings and three stall mixes.",
             errors_seen);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sync_length_packet_deframer.f
rtl/sld_pkg.sv
rtl/sld_skid.sv
rtl/sync_length_packet_deframer.sv
tb/sv/tb_top.sv
